// ===== src/emtp_pkg.sv =====
// Shared types, event codes and the base64 decoder for the markup token parser.
package emtp_pkg;

  localparam int MaxEvents = 4;

  localparam logic [2:0] EV_TEXT     = 3'd0;
  localparam logic [2:0] EV_TEXT_END = 3'd1;
  localparam logic [2:0] EV_LABEL    = 3'd2;
  localparam logic [2:0] EV_OPEN_END = 3'd3;
  localparam logic [2:0] EV_CLOSE    = 3'd4;
  localparam logic [2:0] EV_SPLIT    = 3'd5;
  localparam logic [2:0] EV_BIN      = 3'd6;
  localparam logic [2:0] EV_BIN_END  = 3'd7;

  localparam logic [7:0] CH_TOKEN  = 8'h01;
  localparam logic [7:0] CH_ESCAPE = 8'h02;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_OPEN   = 8'h4F;
  localparam logic [7:0] CH_CLOSE  = 8'h43;
  localparam logic [7:0] CH_SPLIT  = 8'h53;
  localparam logic [7:0] CH_BIN    = 8'h42;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } event_t;

  // All events caused by one input item, slot 0 first.
  typedef struct packed {
    event_t [MaxEvents-1:0] ev;
    logic [2:0]             count;
  } bundle_t;

  function automatic bundle_t push_ev(bundle_t bi, logic [2:0] k, logic [7:0] d);
    bundle_t bo;
    bo = bi;
    if (bi.count < 3'(MaxEvents)) begin
      bo.ev[bi.count[1:0]].kind = k;
      bo.ev[bi.count[1:0]].data = d;
      bo.count = bi.count + 3'd1;
    end
    return bo;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'd65)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'd71)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c + 8'd4)};
    else if (c == 8'h2B)               r = {1'b1, 6'd62};
    else if (c == 8'h2F)               r = {1'b1, 6'd63};
    return r;
  endfunction

endpackage

// ===== src/emtp_front.sv =====
// Front end: parse state, classifies each byte into a bundle of events.
module emtp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               end_of_message,
  input  logic               q_full,
  output logic               q_push,
  output emtp_pkg::bundle_t  q_data
);

  localparam logic [1:0] MODE_TEXT    = 2'd0;
  localparam logic [1:0] MODE_ESC     = 2'd1;
  localparam logic [1:0] MODE_TYPE    = 2'd2;
  localparam logic [1:0] MODE_PAYLOAD = 2'd3;

  localparam logic [2:0] TK_OTHER = 3'd0;
  localparam logic [2:0] TK_OPEN  = 3'd1;
  localparam logic [2:0] TK_CLOSE = 3'd2;
  localparam logic [2:0] TK_SPLIT = 3'd3;
  localparam logic [2:0] TK_BIN   = 3'd4;

  logic [1:0]  mode, mode_next;
  logic [2:0]  kind, kind_next;
  logic        pend, pend_next;
  logic [17:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic        accept;
  emtp_pkg::bundle_t bnd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (bnd.count != 3'd0);
  assign q_data   = bnd;

  always_comb begin
    logic [6:0]  sx;
    logic [23:0] full;
    logic        do_finish;
    bnd       = '0;
    mode_next = mode;
    kind_next = kind;
    pend_next = pend;
    acc_next  = acc;
    cnt_next  = cnt;
    do_finish = 1'b0;
    sx        = emtp_pkg::sextet_of(in_byte);
    full      = {acc, sx[5:0]};

    unique case (mode)
      MODE_TEXT: begin
        if (in_byte == emtp_pkg::CH_TOKEN) begin
          if (pend) bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT_END, 8'd0);
          pend_next = 1'b0;
          mode_next = MODE_TYPE;
        end else if (in_byte == emtp_pkg::CH_ESCAPE) begin
          mode_next = MODE_ESC;
        end else begin
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT, in_byte);
          pend_next = 1'b1;
        end
      end
      MODE_ESC: begin
        if (in_byte == emtp_pkg::CH_ONE)
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT, 8'h01);
        else if (in_byte == emtp_pkg::CH_TWO)
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT, 8'h02);
        else
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT, in_byte);
        pend_next = 1'b1;
        mode_next = MODE_TEXT;
      end
      MODE_TYPE: begin
        if (in_byte == emtp_pkg::CH_OPEN)       kind_next = TK_OPEN;
        else if (in_byte == emtp_pkg::CH_CLOSE) kind_next = TK_CLOSE;
        else if (in_byte == emtp_pkg::CH_SPLIT) kind_next = TK_SPLIT;
        else if (in_byte == emtp_pkg::CH_BIN)   kind_next = TK_BIN;
        else                                    kind_next = TK_OTHER;
        acc_next  = '0;
        cnt_next  = '0;
        mode_next = MODE_PAYLOAD;
      end
      MODE_PAYLOAD: begin
        if (in_byte == emtp_pkg::CH_TOKEN) begin
          do_finish = 1'b1;
          mode_next = MODE_TEXT;
        end else if (kind == TK_OPEN) begin
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_LABEL, in_byte);
        end else if (kind == TK_BIN && sx[6]) begin
          if (cnt == 2'd3) begin
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, full[23:16]);
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, full[15:8]);
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, full[7:0]);
            acc_next = '0;
            cnt_next = '0;
          end else begin
            acc_next = {acc[11:0], sx[5:0]};
            cnt_next = cnt + 2'd1;
          end
        end
      end
      default: ;
    endcase

    // end of message closes an open token payload
    if (end_of_message && mode_next == MODE_PAYLOAD) do_finish = 1'b1;

    if (do_finish) begin
      case (kind_next)
        TK_OPEN:  bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_OPEN_END, 8'd0);
        TK_CLOSE: bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_CLOSE, 8'd0);
        TK_SPLIT: bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_SPLIT, 8'd0);
        TK_BIN: begin
          if (cnt_next == 2'd2) begin
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, acc_next[11:4]);
          end else if (cnt_next == 2'd3) begin
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, acc_next[17:10]);
            bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN, acc_next[9:2]);
          end
          bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_BIN_END, 8'd0);
        end
        default: ;
      endcase
      kind_next = TK_OTHER;
      acc_next  = '0;
      cnt_next  = '0;
    end

    if (end_of_message) begin
      if (pend_next) bnd = emtp_pkg::push_ev(bnd, emtp_pkg::EV_TEXT_END, 8'd0);
      mode_next = MODE_TEXT;
      kind_next = TK_OTHER;
      pend_next = 1'b0;
      acc_next  = '0;
      cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      kind <= TK_OTHER;
      pend <= 1'b0;
      acc  <= '0;
      cnt  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      kind <= kind_next;
      pend <= pend_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_data.count != 3'd0 && q_data.count <= 3'(emtp_pkg::MaxEvents)))
    else $error("front pushed a bundle with a bad event count");

  a_eom_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_message) |=> (mode == MODE_TEXT && !pend && cnt == 2'd0))
    else $error("parse state not cleared after end of message");

endmodule

// ===== src/emtp_queue.sv =====
// Small register queue of event bundles between front and back.
module emtp_queue #(
  parameter int Depth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  emtp_pkg::bundle_t  wr_data,
  input  logic               pop,
  output emtp_pkg::bundle_t  rd_data,
  output logic               full,
  output logic               empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  emtp_pkg::bundle_t mem [Depth];
  logic [AW:0] wptr, rptr;

  assign empty   = (wptr == rptr);
  assign full    = (wptr[AW-1:0] == rptr[AW-1:0]) && (wptr[AW] != rptr[AW]);
  assign rd_data = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) mem[wptr[AW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) wptr <= wptr + (AW+1)'(1);
      if (pop)  rptr <= rptr + (AW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule

// ===== src/emtp_back.sv =====
// Back end: queue bundles load an output register one event per cycle unless stalled.
module emtp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  emtp_pkg::bundle_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_kind,
  output logic [7:0]         event_byte,
  output logic               last_of_run
);

  logic [1:0] sub;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign at_last = ({1'b0, sub} == (q_data.count - 3'd1));
  assign q_pop   = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= at_last ? 2'd0 : sub + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind  <= q_data.ev[sub].kind;
      event_byte  <= q_data.ev[sub].data;
      last_of_run <= at_last;
    end
  end

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid && last_of_run && sub == 2'd0))
    else $error("bundle retired without its last event");

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> ({1'b0, sub} < q_data.count))
    else $error("event index beyond bundle size");

endmodule

// ===== src/escaped_markup_token_parser.sv =====
// Escaped markup token parser: splits a markup byte stream into text/token events.
//
// Input channel (in_valid/in_ready): one markup byte per item, with
// end_of_message set on the last byte of a message. Output channel
// (out_valid/out_ready): one event per item (event_kind, event_byte),
// last_of_run set on the final event caused by an input byte. A byte may
// cause zero to four events; bytes that cause none produce no output.
//
// Throughput: one input byte per cycle while the bundle queue has room;
// the output side moves one event per cycle while out_ready is high, so
// the events of a byte leave in order, slot 0 first. The first event of a byte
// is written into the bundle queue, then loaded into the output register.
// The queue holds QUEUE_DEPTH bundles; in_ready drops only when it is full.
//
// Reset clears the parse state and the queue; the next byte starts a new
// message. When the receiver stalls, events wait in the output register
// and the queue, and input keeps flowing until the queue fills.
module escaped_markup_token_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [7:0] event_byte,
  output logic       last_of_run
);

  emtp_pkg::bundle_t wr_bundle, rd_bundle;
  logic q_push, q_pop, q_full, q_empty;

  emtp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (wr_bundle)
  );

  emtp_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (wr_bundle),
    .pop     (q_pop),
    .rd_data (rd_bundle),
    .full    (q_full),
    .empty   (q_empty)
  );

  emtp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (rd_bundle),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .event_byte  (event_byte),
    .last_of_run (last_of_run)
  );

endmodule
